// ===== hw/rtl/rtp_pkg.sv =====
// Shared constants, angle table and result word type for the rectangular to polar block.
package rtp_pkg;

   // Default sizes handed to the top level
   localparam int DEFAULT_SAMPLE_WIDTH  = 16;
   localparam int DEFAULT_CORDIC_STAGES = 16;

   // Rotation datapath: components scaled so the top sits just under bit 60
   localparam int CORDIC_WIDTH = 64;
   localparam int GUARD_TOP    = 60;

   // Angle accumulator in units of 2^-23 degree
   localparam int ACC_WIDTH  = 34;
   localparam int TURN_WIDTH = 32;
   localparam logic signed [ACC_WIDTH-1:0] HALF_TURN = 34'sd1509949440;
   localparam logic signed [ACC_WIDTH-1:0] FULL_TURN = 34'sd3019898880;

   // Output rounding: drop 16 bits, round half up, wrap a full turn
   localparam int ROUND_SHIFT = 16;
   localparam int STEP_WIDTH  = TURN_WIDTH + 1 - ROUND_SHIFT;
   localparam logic [TURN_WIDTH:0]   ROUND_HALF    = 33'd32768;
   localparam logic [STEP_WIDTH-1:0] FULL_TURN_OUT = 17'd46080;

   // Result field widths
   localparam int MAG_WIDTH   = 16;
   localparam int ANGLE_WIDTH = 16;

   // atan(2^-i) in degrees times 2^23, rounded
   localparam int ATAN_TABLE_LEN = 32;
   localparam logic signed [ACC_WIDTH-1:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      34'sd377487360, 34'sd222843801, 34'sd117744544, 34'sd59768969,
      34'sd30000467,  34'sd15014858,  34'sd7509261,   34'sd3754860,
      34'sd1877459,   34'sd938733,    34'sd469367,    34'sd234683,
      34'sd117342,    34'sd58671,     34'sd29335,     34'sd14668,
      34'sd7334,      34'sd3667,      34'sd1833,      34'sd917,
      34'sd458,       34'sd229,       34'sd115,       34'sd57,
      34'sd29,        34'sd14,        34'sd7,         34'sd4,
      34'sd2,         34'sd1,         34'sd0,         34'sd0
   };

   // One result word
   typedef struct packed {
      logic [MAG_WIDTH-1:0]   magnitude;
      logic [ANGLE_WIDTH-1:0] angle;
      logic                   zero_vector;
   } rsp_word_type;

endpackage

// ===== hw/rtl/rectangular_to_polar.sv =====
// Rectangular to polar converter: 3 front stages (fold, squares, sum), one stage per
// rotation step and root digit, whichever count is larger, 2 rounding stages and the
// output register. Throughput is one word per cycle; the pipeline only holds while the
// output skid slot is full. Reset clears all valid bits; no word is in flight afterward.
module rectangular_to_polar #(
   parameter int SAMPLE_WIDTH  = rtp_pkg::DEFAULT_SAMPLE_WIDTH,
   parameter int CORDIC_STAGES = rtp_pkg::DEFAULT_CORDIC_STAGES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_x_component,
   input  logic signed [SAMPLE_WIDTH-1:0] req_y_component,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rtp_pkg::MAG_WIDTH-1:0]   rsp_magnitude,
   output logic [rtp_pkg::ANGLE_WIDTH-1:0] rsp_angle,
   output logic                           rsp_zero_vector
);
   import rtp_pkg::*;

   localparam int DEPTH = (CORDIC_STAGES > SAMPLE_WIDTH) ? CORDIC_STAGES : SAMPLE_WIDTH;
   localparam int RADW  = 2 * SAMPLE_WIDTH;
   localparam int REMW  = SAMPLE_WIDTH + 2;

   logic                           adv;
   logic                           st_valid [DEPTH+1];
   logic                           st_zero  [DEPTH+1];
   logic signed [CORDIC_WIDTH-1:0] st_cx    [DEPTH+1];
   logic signed [CORDIC_WIDTH-1:0] st_cy    [DEPTH+1];
   logic signed [ACC_WIDTH-1:0]    st_acc   [DEPTH+1];
   logic [RADW-1:0]                st_rad   [DEPTH+1];
   logic [REMW-1:0]                st_rem   [DEPTH+1];
   logic [SAMPLE_WIDTH-1:0]        st_root  [DEPTH+1];
   logic                           fin_valid;
   rsp_word_type                   fin_word, rsp_word;

   assign req_ready = adv;

   // fold, squares and radicand
   rtp_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .x_in     (req_x_component),
      .y_in     (req_y_component),
      .out_valid(st_valid[0]),
      .out_zero (st_zero[0]),
      .cx_out   (st_cx[0]),
      .cy_out   (st_cy[0]),
      .acc_out  (st_acc[0]),
      .rad_out  (st_rad[0])
   );

   // root digits start from an empty remainder and root
   assign st_rem[0]  = '0;
   assign st_root[0] = '0;

   // rotation and root-digit stages
   for (genvar i = 0; i < DEPTH; i++) begin : g_stage
      rtp_iter #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .CORDIC_STAGES(CORDIC_STAGES),
         .INDEX        (i)
      ) u_iter (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (st_valid[i]),
         .in_zero  (st_zero[i]),
         .cx_in    (st_cx[i]),
         .cy_in    (st_cy[i]),
         .acc_in   (st_acc[i]),
         .rad_in   (st_rad[i]),
         .rem_in   (st_rem[i]),
         .root_in  (st_root[i]),
         .out_valid(st_valid[i+1]),
         .out_zero (st_zero[i+1]),
         .cx_out   (st_cx[i+1]),
         .cy_out   (st_cy[i+1]),
         .acc_out  (st_acc[i+1]),
         .rad_out  (st_rad[i+1]),
         .rem_out  (st_rem[i+1]),
         .root_out (st_root[i+1])
      );
   end

   // rounding and zero-vector override
   rtp_finish #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_finish (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (st_valid[DEPTH]),
      .in_zero  (st_zero[DEPTH]),
      .acc_in   (st_acc[DEPTH]),
      .rem_in   (st_rem[DEPTH]),
      .root_in  (st_root[DEPTH]),
      .out_valid(fin_valid),
      .out_word (fin_word)
   );

   // output register and skid slot
   rtp_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fin_valid),
      .in_word  (fin_word),
      .adv      (adv),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

   assign rsp_magnitude   = rsp_word.magnitude;
   assign rsp_angle       = rsp_word.angle;
   assign rsp_zero_vector = rsp_word.zero_vector;

endmodule

// ===== hw/rtl/rtp_front.sv =====
// Front end: half-plane fold, absolute values, squares and their sum.
module rtp_front #(
   parameter int SAMPLE_WIDTH = rtp_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0]        x_in,
   input  logic signed [SAMPLE_WIDTH-1:0]        y_in,
   output logic                                  out_valid,
   output logic                                  out_zero,
   output logic signed [rtp_pkg::CORDIC_WIDTH-1:0] cx_out,
   output logic signed [rtp_pkg::CORDIC_WIDTH-1:0] cy_out,
   output logic signed [rtp_pkg::ACC_WIDTH-1:0]    acc_out,
   output logic [2*SAMPLE_WIDTH-1:0]             rad_out
);
   import rtp_pkg::*;

   localparam int GUARD = GUARD_TOP - SAMPLE_WIDTH;
   localparam int RADW  = 2 * SAMPLE_WIDTH;

   // stage 0 registers
   logic                           s0_valid_ff, s0_zero_ff, s0_zero_in;
   logic signed [CORDIC_WIDTH-1:0] s0_cx_ff, s0_cy_ff, s0_cx_in, s0_cy_in;
   logic signed [ACC_WIDTH-1:0]    s0_acc_ff, s0_acc_in;
   logic [SAMPLE_WIDTH-1:0]        s0_ux_ff, s0_uy_ff, s0_ux_in, s0_uy_in;
   logic signed [CORDIC_WIDTH-1:0] x_wide, y_wide;

   // stage 1 registers
   logic                           s1_valid_ff, s1_zero_ff;
   logic signed [CORDIC_WIDTH-1:0] s1_cx_ff, s1_cy_ff;
   logic signed [ACC_WIDTH-1:0]    s1_acc_ff;
   logic [RADW-1:0]                s1_sqx_ff, s1_sqy_ff, s1_sqx_in, s1_sqy_in;

   // stage 2 registers
   logic                           s2_valid_ff, s2_zero_ff;
   logic signed [CORDIC_WIDTH-1:0] s2_cx_ff, s2_cy_ff;
   logic signed [ACC_WIDTH-1:0]    s2_acc_ff;
   logic [RADW-1:0]                s2_rad_ff, s2_rad_in;

   // fold the left half-plane over by a half turn; take magnitudes
   always_comb begin
      x_wide     = CORDIC_WIDTH'(x_in) <<< GUARD;
      y_wide     = CORDIC_WIDTH'(y_in) <<< GUARD;
      s0_zero_in = (x_in == '0) && (y_in == '0);
      s0_ux_in   = x_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-x_in) : SAMPLE_WIDTH'(x_in);
      s0_uy_in   = y_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-y_in) : SAMPLE_WIDTH'(y_in);
      if (x_in[SAMPLE_WIDTH-1]) begin
         s0_cx_in  = -x_wide;
         s0_cy_in  = -y_wide;
         s0_acc_in = HALF_TURN;
      end else begin
         s0_cx_in  = x_wide;
         s0_cy_in  = y_wide;
         s0_acc_in = '0;
      end
   end

   // squares
   always_comb begin
      s1_sqx_in = RADW'(s0_ux_ff) * RADW'(s0_ux_ff);
      s1_sqy_in = RADW'(s0_uy_ff) * RADW'(s0_uy_ff);
   end

   // radicand, cannot overflow: each square is at most 2^(2W-2)
   assign s2_rad_in = s1_sqx_ff + s1_sqy_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_zero_ff <= s0_zero_in;
         s0_cx_ff   <= s0_cx_in;
         s0_cy_ff   <= s0_cy_in;
         s0_acc_ff  <= s0_acc_in;
         s0_ux_ff   <= s0_ux_in;
         s0_uy_ff   <= s0_uy_in;
         s1_zero_ff <= s0_zero_ff;
         s1_cx_ff   <= s0_cx_ff;
         s1_cy_ff   <= s0_cy_ff;
         s1_acc_ff  <= s0_acc_ff;
         s1_sqx_ff  <= s1_sqx_in;
         s1_sqy_ff  <= s1_sqy_in;
         s2_zero_ff <= s1_zero_ff;
         s2_cx_ff   <= s1_cx_ff;
         s2_cy_ff   <= s1_cy_ff;
         s2_acc_ff  <= s1_acc_ff;
         s2_rad_ff  <= s2_rad_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_zero  = s2_zero_ff;
   assign cx_out    = s2_cx_ff;
   assign cy_out    = s2_cy_ff;
   assign acc_out   = s2_acc_ff;
   assign rad_out   = s2_rad_ff;

endmodule

// ===== hw/rtl/rtp_iter.sv =====
// One stage: a vectoring rotation step and/or one root digit.
module rtp_iter #(
   parameter int SAMPLE_WIDTH  = rtp_pkg::DEFAULT_SAMPLE_WIDTH,
   parameter int CORDIC_STAGES = rtp_pkg::DEFAULT_CORDIC_STAGES,
   parameter int INDEX         = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic                                  in_zero,
   input  logic signed [rtp_pkg::CORDIC_WIDTH-1:0] cx_in,
   input  logic signed [rtp_pkg::CORDIC_WIDTH-1:0] cy_in,
   input  logic signed [rtp_pkg::ACC_WIDTH-1:0]    acc_in,
   input  logic [2*SAMPLE_WIDTH-1:0]             rad_in,
   input  logic [SAMPLE_WIDTH+1:0]               rem_in,
   input  logic [SAMPLE_WIDTH-1:0]               root_in,
   output logic                                  out_valid,
   output logic                                  out_zero,
   output logic signed [rtp_pkg::CORDIC_WIDTH-1:0] cx_out,
   output logic signed [rtp_pkg::CORDIC_WIDTH-1:0] cy_out,
   output logic signed [rtp_pkg::ACC_WIDTH-1:0]    acc_out,
   output logic [2*SAMPLE_WIDTH-1:0]             rad_out,
   output logic [SAMPLE_WIDTH+1:0]               rem_out,
   output logic [SAMPLE_WIDTH-1:0]               root_out
);
   import rtp_pkg::*;

   localparam int  RADW      = 2 * SAMPLE_WIDTH;
   localparam int  REMW      = SAMPLE_WIDTH + 2;
   localparam int  RAWW      = SAMPLE_WIDTH + 4;
   localparam bit  DO_CORDIC = INDEX < CORDIC_STAGES;
   localparam bit  DO_SQRT   = INDEX < SAMPLE_WIDTH;

   logic                           valid_ff, zero_ff;
   logic signed [CORDIC_WIDTH-1:0] cx_ff, cy_ff, cx_in_n, cy_in_n;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in_n;
   logic [RADW-1:0]                rad_ff, rad_in_n;
   logic [REMW-1:0]                rem_ff, rem_in_n;
   logic [SAMPLE_WIDTH-1:0]        root_ff, root_in_n;

   // rotation step: drive y toward zero, accumulate the angle turned
   if (DO_CORDIC) begin : g_rot
      logic signed [CORDIC_WIDTH-1:0] dx, dy;
      always_comb begin
         dx = cy_in >>> INDEX;
         dy = cx_in >>> INDEX;
         if (!cy_in[CORDIC_WIDTH-1]) begin
            cx_in_n  = cx_in + dx;
            cy_in_n  = cy_in - dy;
            acc_in_n = acc_in + ATAN_TABLE[INDEX];
         end else begin
            cx_in_n  = cx_in - dx;
            cy_in_n  = cy_in + dy;
            acc_in_n = acc_in - ATAN_TABLE[INDEX];
         end
      end
   end else begin : g_rot_pass
      always_comb begin
         cx_in_n  = cx_in;
         cy_in_n  = cy_in;
         acc_in_n = acc_in;
      end
   end

   // root digit: bring down two radicand bits, try root*4+1
   if (DO_SQRT) begin : g_root
      logic [RAWW-1:0] raw, trial;
      logic            fits;
      always_comb begin
         raw       = {rem_in, rad_in[RADW-1 -: 2]};
         trial     = RAWW'({root_in, 2'b01});
         fits      = raw >= trial;
         rem_in_n  = fits ? REMW'(raw - trial) : REMW'(raw);
         root_in_n = {root_in[SAMPLE_WIDTH-2:0], fits};
         rad_in_n  = rad_in << 2;
      end
   end else begin : g_root_pass
      always_comb begin
         rem_in_n  = rem_in;
         root_in_n = root_in;
         rad_in_n  = rad_in;
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= in_zero;
         cx_ff   <= cx_in_n;
         cy_ff   <= cy_in_n;
         acc_ff  <= acc_in_n;
         rad_ff  <= rad_in_n;
         rem_ff  <= rem_in_n;
         root_ff <= root_in_n;
      end
   end

   assign out_valid = valid_ff;
   assign out_zero  = zero_ff;
   assign cx_out    = cx_ff;
   assign cy_out    = cy_ff;
   assign acc_out   = acc_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;

endmodule

// ===== hw/rtl/rtp_finish.sv =====
// Back end: angle wrap and rounding, root rounding, zero-vector override.
module rtp_finish #(
   parameter int SAMPLE_WIDTH = rtp_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic                               in_zero,
   input  logic signed [rtp_pkg::ACC_WIDTH-1:0] acc_in,
   input  logic [SAMPLE_WIDTH+1:0]            rem_in,
   input  logic [SAMPLE_WIDTH-1:0]            root_in,
   output logic                               out_valid,
   output rtp_pkg::rsp_word_type              out_word
);
   import rtp_pkg::*;

   localparam int REMW = SAMPLE_WIDTH + 2;

   // stage 0
   logic                    b0_valid_ff, b0_zero_ff;
   logic [TURN_WIDTH-1:0]   b0_turn_ff, b0_turn_in;
   logic [SAMPLE_WIDTH-1:0] b0_mag_ff, b0_mag_in;

   // stage 1
   logic                    b1_valid_ff;
   rsp_word_type            b1_word_ff, b1_word_in;
   logic [TURN_WIDTH:0]     rounded;
   logic [STEP_WIDTH-1:0]   steps;

   // bring the angle into one positive turn; round root to nearest
   always_comb begin
      if (acc_in[ACC_WIDTH-1]) begin
         b0_turn_in = TURN_WIDTH'(acc_in + FULL_TURN);
      end else begin
         b0_turn_in = TURN_WIDTH'(acc_in);
      end
      b0_mag_in = root_in + SAMPLE_WIDTH'(rem_in > REMW'(root_in));
   end

   // drop fraction bits with half-up rounding; a full turn wraps to zero
   always_comb begin
      rounded = (TURN_WIDTH + 1)'(b0_turn_ff) + ROUND_HALF;
      steps   = rounded[TURN_WIDTH:ROUND_SHIFT];
      if (steps >= FULL_TURN_OUT) begin
         steps = steps - FULL_TURN_OUT;
      end
      b1_word_in.zero_vector = b0_zero_ff;
      if (b0_zero_ff) begin
         b1_word_in.magnitude = '0;
         b1_word_in.angle     = '0;
      end else begin
         b1_word_in.magnitude = MAG_WIDTH'(b0_mag_ff);
         b1_word_in.angle     = ANGLE_WIDTH'(steps);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
      end else if (adv) begin
         b0_valid_ff <= in_valid;
         b1_valid_ff <= b0_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         b0_zero_ff <= in_zero;
         b0_turn_ff <= b0_turn_in;
         b0_mag_ff  <= b0_mag_in;
         b1_word_ff <= b1_word_in;
      end
   end

   assign out_valid = b1_valid_ff;
   assign out_word  = b1_word_ff;

endmodule

// ===== hw/rtl/rtp_out_buf.sv =====
// Output register with a skid slot; the pipeline advances while the slot is empty.
module rtp_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rtp_pkg::rsp_word_type in_word,
   output logic                  adv,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rtp_pkg::rsp_word_type rsp_word
);
   import rtp_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         take_out, push;

   assign adv      = !skid_valid_ff;
   assign take_out = out_valid_ff && rsp_ready;
   assign push     = adv && in_valid;

   // next state of the two slots
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take_out) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take_out) begin
            out_word_in  = in_word;
            out_valid_in = 1'b1;
         end else begin
            skid_word_in  = in_word;
            skid_valid_in = 1'b1;
         end
      end else if (take_out) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
